>>> hw/rtl/lpcp_pkg.sv
package lpcp_pkg;

  // Filter box limits on raw Q16.16 / Q0.16 words
  localparam logic signed [31:0] X_MAX_RAW     = 32'sd1638400;  // 25.0 m
  localparam logic signed [31:0] Y_ABS_MAX_RAW = 32'sd393216;   // 6.0 m
  localparam logic signed [31:0] Z_MIN_RAW     = -32'sd91750;   // -1.4 m
  localparam logic [15:0]        R_MIN_RAW     = 16'd656;       // 0.01

  // Result status codes
  localparam logic [1:0] ST_INSIDE   = 2'd0;
  localparam logic [1:0] ST_FILTERED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_DEPTH    = 2'd3;

  // Configuration register indexes
  localparam logic [3:0] REG_ROW0_C01 = 4'd0;
  localparam logic [3:0] REG_ROW0_C23 = 4'd1;
  localparam logic [3:0] REG_ROW1_C01 = 4'd2;
  localparam logic [3:0] REG_ROW1_C23 = 4'd3;
  localparam logic [3:0] REG_ROW2_C01 = 4'd4;
  localparam logic [3:0] REG_ROW2_C23 = 4'd5;
  localparam logic [3:0] REG_IMG_W    = 4'd6;
  localparam logic [3:0] REG_IMG_H    = 4'd7;

  localparam int FRONT_STAGES = 4;

  typedef logic signed [31:0] coef_t;

  // Row sums handed from the matrix front end to the divider
  typedef struct packed {
    logic signed [63:0] su;
    logic signed [63:0] sv;
    logic signed [63:0] sw;
    logic [1:0]         status;
  } lpcp_sums_t;

endpackage

>>> hw/rtl/lpcp_front.sv
module lpcp_front (
  input  logic                       clk,
  input  logic [3:0]                 en_i,
  input  logic signed [31:0]         point_x,
  input  logic signed [31:0]         point_y,
  input  logic signed [31:0]         point_z,
  input  logic [15:0]                reflectivity,
  input  lpcp_pkg::coef_t            coef_i [3][4],
  output lpcp_pkg::lpcp_sums_t       sums_o
);
  import lpcp_pkg::*;

  logic signed [31:0] x_r, y_r, z_r;
  logic               filt_r, filt2_r, filt3_r;
  logic signed [63:0] prod_r [3][4];
  logic signed [63:0] pa_r [3];
  logic signed [63:0] pb_r [3];
  lpcp_sums_t         sums_r;
  logic               filt_nxt;

  // Box filter on the raw words
  assign filt_nxt = (point_x > X_MAX_RAW) || (point_x < 32'sd0) ||
                    (point_y > Y_ABS_MAX_RAW) || (point_y < -Y_ABS_MAX_RAW) ||
                    (point_z < Z_MIN_RAW) || (reflectivity < R_MIN_RAW);

  // Stage 0: capture point
  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      x_r    <= point_x;
      y_r    <= point_y;
      z_r    <= point_z;
      filt_r <= filt_nxt;
    end
  end

  // Stage 1: nine 32x32 products, constant column scaled to Q32.32
  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= x_r * coef_i[r][0];
        prod_r[r][1] <= y_r * coef_i[r][1];
        prod_r[r][2] <= z_r * coef_i[r][2];
        prod_r[r][3] <= 64'(coef_i[r][3]) <<< 16;
      end
      filt2_r <= filt_r;
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (en_i[2]) begin
      for (int r = 0; r < 3; r++) begin
        pa_r[r] <= prod_r[r][0] + prod_r[r][1];
        pb_r[r] <= prod_r[r][2] + prod_r[r][3];
      end
      filt3_r <= filt2_r;
    end
  end

  // Stage 3: row sums
  always_ff @(posedge clk) begin
    if (en_i[3]) begin
      sums_r.su     <= pa_r[0] + pb_r[0];
      sums_r.sv     <= pa_r[1] + pb_r[1];
      sums_r.sw     <= pa_r[2] + pb_r[2];
      sums_r.status <= filt3_r ? ST_FILTERED : ST_INSIDE;
    end
  end

  assign sums_o = sums_r;

endmodule

>>> hw/rtl/lpcp_div.sv
module lpcp_div #(
  parameter int QB = 12
) (
  input  logic                 clk,
  input  logic [QB+1:0]        en_i,
  input  lpcp_pkg::lpcp_sums_t sums_i,
  input  logic [QB:0]          wl_i,
  input  logic [QB:0]          hl_i,
  output logic [11:0]          pixel_col,
  output logic [11:0]          pixel_row,
  output logic [1:0]           status
);
  import lpcp_pkg::*;

  localparam int DW = 64 + QB;
  localparam int PW = (QB > 12) ? QB : 12;

  // Per-stage state; index 0 is the setup stage, QB is after the last step
  logic [63:0]   rem_u_r [QB+1];
  logic [63:0]   rem_v_r [QB+1];
  logic [63:0]   sw_r    [QB+1];
  logic [QB-1:0] q_u_r   [QB+1];
  logic [QB-1:0] q_v_r   [QB+1];
  logic [1:0]    st_r    [QB+1];

  logic [1:0]    st_nxt;
  logic          out_u, out_v;
  logic [64:0]   sum_u, sum_v;
  logic [DW-1:0] sw_top;

  logic [11:0]   col_r, row_r;
  logic [1:0]    stat_r;

  // Setup: depth check and range of quotient
  always_comb begin
    sw_top = {sums_i.sw, {QB{1'b0}}};
    sum_u  = {sums_i.su[63], sums_i.su} + {sums_i.sw[63], sums_i.sw};
    sum_v  = {sums_i.sv[63], sums_i.sv} + {sums_i.sw[63], sums_i.sw};
    // negative numerator: quotient is zero unless |num| >= den
    if (sums_i.su[63]) out_u = $signed(sum_u) <= 65'sd0;
    else               out_u = {{QB{1'b0}}, sums_i.su} >= sw_top;
    if (sums_i.sv[63]) out_v = $signed(sum_v) <= 65'sd0;
    else               out_v = {{QB{1'b0}}, sums_i.sv} >= sw_top;
    st_nxt = sums_i.status;
    if (sums_i.status == ST_INSIDE) begin
      if (sums_i.sw <= 64'sd0)  st_nxt = ST_DEPTH;
      else if (out_u || out_v) st_nxt = ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      rem_u_r[0] <= sums_i.su[63] ? 64'd0 : sums_i.su;
      rem_v_r[0] <= sums_i.sv[63] ? 64'd0 : sums_i.sv;
      sw_r[0]    <= sums_i.sw;
      q_u_r[0]   <= '0;
      q_v_r[0]   <= '0;
      st_r[0]    <= st_nxt;
    end
  end

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int B = QB - 1 - i;
    logic [DW-1:0] d;
    logic          ge_u, ge_v;
    logic [DW-1:0] du, dv;

    assign d    = {{QB{1'b0}}, sw_r[i]} << B;
    assign ge_u = {{QB{1'b0}}, rem_u_r[i]} >= d;
    assign ge_v = {{QB{1'b0}}, rem_v_r[i]} >= d;
    assign du   = {{QB{1'b0}}, rem_u_r[i]} - d;
    assign dv   = {{QB{1'b0}}, rem_v_r[i]} - d;

    always_ff @(posedge clk) begin
      if (en_i[i+1]) begin
        rem_u_r[i+1] <= ge_u ? du[63:0] : rem_u_r[i];
        rem_v_r[i+1] <= ge_v ? dv[63:0] : rem_v_r[i];
        q_u_r[i+1]   <= q_u_r[i] | (QB'(ge_u) << B);
        q_v_r[i+1]   <= q_v_r[i] | (QB'(ge_v) << B);
        sw_r[i+1]    <= sw_r[i];
        st_r[i+1]    <= st_r[i];
      end
    end
  end

  // Output stage: image bounds and masking
  logic [1:0]  st_fin;
  logic [PW-1:0] qu_ext, qv_ext;

  always_comb begin
    st_fin = st_r[QB];
    if (st_fin == ST_INSIDE &&
        ({1'b0, q_u_r[QB]} >= wl_i || {1'b0, q_v_r[QB]} >= hl_i))
      st_fin = ST_OUTSIDE;
    qu_ext = PW'(q_u_r[QB]);
    qv_ext = PW'(q_v_r[QB]);
  end

  always_ff @(posedge clk) begin
    if (en_i[QB+1]) begin
      stat_r <= st_fin;
      col_r  <= (st_fin == ST_INSIDE) ? qu_ext[11:0] : 12'd0;
      row_r  <= (st_fin == ST_INSIDE) ? qv_ext[11:0] : 12'd0;
    end
  end

  assign pixel_col = col_r;
  assign pixel_row = row_r;
  assign status    = stat_r;

endmodule

>>> hw/rtl/lidar_point_camera_projection_top.sv
// Lidar point to camera pixel projection.
// Input stream: one lidar point per transfer (x, y, z in Q16.16, reflectivity
// Q0.16). Points outside the fixed box are flagged as filtered; kept points
// are multiplied by the loaded 3x4 matrix and divided by the depth row.
// Output stream: one result per point, in order: pixel column, pixel row
// and a status code (inside, filtered, outside image, nonpositive depth).
// Configuration: write-only port, matrix in six 64-bit registers, image
// width and height; write only while the pipeline is empty.
// Throughput: one point per cycle while the receiver keeps up. The pipeline
// has four front stages (capture, multiply, two adds), a setup
// stage, one restoring-division stage per quotient bit and an output stage.
// Reset clears every stage valid and reloads the register defaults (zero
// matrix, 1242 x 375 image). When the receiver stalls, the pipeline holds;
// empty stages keep filling, so input is taken until every stage is full.
module lidar_point_camera_projection_top #(
  parameter int MAX_IMAGE_SIDE = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // point_x, point_y, point_z, reflectivity
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // pixel_col, pixel_row, status, zero pad
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  import lpcp_pkg::*;

  localparam int QB = $clog2(MAX_IMAGE_SIDE);
  localparam int WB = QB + 1;
  localparam int CW = (WB > 13) ? WB : 13;
  localparam int NS = FRONT_STAGES + QB + 2;

  logic [63:0]   mat_r [6];
  logic [12:0]   img_w_r, img_h_r;
  coef_t         coef [3][4];
  logic [CW-1:0] w_ext, h_ext;
  logic [WB-1:0] wl, hl;

  logic [NS-1:0] v_r, en;
  lpcp_sums_t    sums;
  logic [11:0]   pixel_col, pixel_row;
  logic [1:0]    status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) mat_r[i] <= '0;
      img_w_r <= 13'd1242;
      img_h_r <= 13'd375;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_C01, REG_ROW0_C23, REG_ROW1_C01,
        REG_ROW1_C23, REG_ROW2_C01, REG_ROW2_C23: mat_r[cfg_index[2:0]] <= cfg_wdata;
        REG_IMG_W: img_w_r <= cfg_wdata[12:0];
        REG_IMG_H: img_h_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients: low word is the even column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = mat_r[2*r][31:0];
      coef[r][1] = mat_r[2*r][63:32];
      coef[r][2] = mat_r[2*r+1][31:0];
      coef[r][3] = mat_r[2*r+1][63:32];
    end
  end

  // Clamp image size to the largest supported side
  always_comb begin
    w_ext = CW'(img_w_r);
    h_ext = CW'(img_h_r);
    if (w_ext > CW'(MAX_IMAGE_SIDE)) w_ext = CW'(MAX_IMAGE_SIDE);
    if (h_ext > CW'(MAX_IMAGE_SIDE)) h_ext = CW'(MAX_IMAGE_SIDE);
    wl = WB'(w_ext);
    hl = WB'(h_ext);
  end

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++)
        if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  lpcp_front u_front (
    .clk          (clk),
    .en_i         (en[FRONT_STAGES-1:0]),
    .point_x      (in_tdata[31:0]),
    .point_y      (in_tdata[63:32]),
    .point_z      (in_tdata[95:64]),
    .reflectivity (in_tdata[111:96]),
    .coef_i       (coef),
    .sums_o       (sums)
  );

  lpcp_div #(.QB(QB)) u_div (
    .clk       (clk),
    .en_i      (en[NS-1:FRONT_STAGES]),
    .sums_i    (sums),
    .wl_i      (wl),
    .hl_i      (hl),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .status    (status)
  );

  assign out_tdata = {6'd0, status, pixel_row, pixel_col};

endmodule

>>> hw/rtl/lpcp_checker.sv
module lpcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import lpcp_pkg::*;

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Pixel fields are zero unless the point landed inside the image
  a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[25:24] != ST_INSIDE) |-> out_tdata[23:0] == 24'd0)
    else $error("pixel set on a rejected point");

  // Pad bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:26] == 6'd0)
    else $error("pad bits set");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind lidar_point_camera_projection_top lpcp_checker u_lpcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> sim/lpcp_checker.sv
// Watches both streams, predicts each projection and compares results.
module lpcp_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  import lpcp_pkg::*;

  // status in the top bits, column in the low bits, as on out_tdata
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] row;
    logic [11:0] col;
  } pixel_t;

  logic [63:0] mat_q[6];
  logic [12:0] width_q;
  logic [12:0] height_q;
  pixel_t      expected_pixels[$];

  function automatic logic signed [63:0] coef_of(int r, int c);
    logic [63:0] w;
    w = mat_q[r * 2 + c / 2];
    return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
  endfunction

  function automatic logic signed [63:0] row_sum(int r, logic signed [63:0] x,
                                                 logic signed [63:0] y,
                                                 logic signed [63:0] z);
    return coef_of(r, 0) * x + coef_of(r, 1) * y + coef_of(r, 2) * z
           + (coef_of(r, 3) <<< 16);
  endfunction

  function automatic pixel_t project_point(logic [111:0] d);
    logic signed [63:0] x, y, z, su, sv, sw, c, r, wl, hl;
    logic [15:0] refl;
    pixel_t p;
    x = 64'(signed'(d[31:0]));
    y = 64'(signed'(d[63:32]));
    z = 64'(signed'(d[95:64]));
    refl = d[111:96];
    wl = (width_q > 4096) ? 64'sd4096 : 64'(width_q);
    hl = (height_q > 4096) ? 64'sd4096 : 64'(height_q);
    p = '0;
    if (x > 1638400 || x < 0 || y > 393216 || y < -393216 || z < -91750 ||
        refl < 16'd656) begin
      p.status = ST_FILTERED;
      return p;
    end
    su = row_sum(0, x, y, z);
    sv = row_sum(1, x, y, z);
    sw = row_sum(2, x, y, z);
    if (sw <= 0) begin
      p.status = ST_DEPTH;
      return p;
    end
    c = su / sw;
    r = sv / sw;
    if (c < 0 || c >= wl || r < 0 || r >= hl) begin
      p.status = ST_OUTSIDE;
      return p;
    end
    p.col = c[11:0];
    p.row = r[11:0];
    p.status = ST_INSIDE;
    return p;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      foreach (mat_q[i]) mat_q[i] <= '0;
      width_q <= 13'd1242;
      height_q <= 13'd375;
      fail_count <= 0;
    end else begin
      // register mirror
      if (cfg_we) begin
        if (cfg_index <= REG_ROW2_C23) mat_q[cfg_index] <= cfg_wdata;
        else if (cfg_index == REG_IMG_W) width_q <= cfg_wdata[12:0];
        else if (cfg_index == REG_IMG_H) height_q <= cfg_wdata[12:0];
      end
      if (in_tvalid && in_tready)
        expected_pixels = {expected_pixels, project_point(in_tdata)};
      // compare each result transfer
      if (out_tvalid && out_tready) begin
        got = out_tdata[25:0];
        if (expected_pixels.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got.col != want.col)
            $error("pixel_col expected %0d actual %0d", want.col, got.col);
          if (got.row != want.row)
            $error("pixel_row expected %0d actual %0d", want.row, got.row);
          if (got.status != want.status)
            $error("status expected %0d actual %0d", want.status, got.status);
          if (got != want) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  import lpcp_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;   // point_x, point_y, point_z, reflectivity
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;  // pixel_col, pixel_row, status, zero pad
  logic         cfg_we;
  logic [3:0]   cfg_index;
  logic [63:0]  cfg_wdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           phase_num = -1;
  bit           hold_active;
  int           cycle_count;

  lidar_point_camera_projection_top u_dut (.*);

  lpcp_scoreboard u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    wait (phase_num == 4);
    hold_active = 1'b1;
    repeat (300) @(negedge clk);
    hold_active = 1'b0;
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_active) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    in_tvalid <= 1'b0;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    stop_input();
    while (pending != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  // one point; held until the transfer happens, valid left high for the next
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] refl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {refl, z, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] coef_word(int lo, int hi);
    return 32'($urandom_range(hi - lo) + lo);
  endfunction

  // matrix with mostly positive depth and pixels near the image
  task automatic load_camera(int w, int h);
    write_reg(REG_ROW0_C01, {coef_word(-600000, 600000), coef_word(0, 60000000)});
    write_reg(REG_ROW0_C23, {coef_word(-2000000, 2000000), coef_word(-600000, 600000)});
    write_reg(REG_ROW1_C01, {coef_word(-60000000, 60000000), coef_word(0, 25000000)});
    write_reg(REG_ROW1_C23, {coef_word(-2000000, 2000000), coef_word(-60000000, 60000000)});
    write_reg(REG_ROW2_C01, {coef_word(-20000, 20000), coef_word(30000, 70000)});
    write_reg(REG_ROW2_C23, {coef_word(-200000, 400000), coef_word(-20000, 20000)});
    write_reg(REG_IMG_W, 64'(w));
    write_reg(REG_IMG_H, 64'(h));
  endtask

  task automatic send_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k == 0)
        send_point($urandom, $urandom, $urandom, 16'($urandom));
      else
        send_point(32'($urandom_range(1638400)),
                   32'($urandom_range(786432)) - 32'd393216,
                   32'($urandom_range(400000)) - 32'd91750,
                   16'($urandom_range(65535, 656)));
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: zero matrix after reset gives nonpositive depth
    send_point(32'd100000, 0, 0, 16'd1000);
    drain_pipeline();
    load_camera(1242, 375);
    // filter edges and field extremes
    send_point(32'd1638400, 32'd393216, -32'sd91750, 16'd656);
    send_point(32'd1638401, 0, 0, 16'hFFFF);
    send_point(32'hFFFFFFFF, 0, 0, 16'hFFFF);
    send_point(0, 32'd393217, 0, 16'hFFFF);
    send_point(0, -32'sd393217, 0, 16'hFFFF);
    send_point(0, -32'sd393216, -32'sd91751, 16'hFFFF);
    send_point(32'd800000, 0, 32'h7FFFFFFF, 16'd655);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'd0);
    send_point(0, 0, 32'h7FFFFFFF, 16'hFFFF);
    send_point(32'd655360, 0, 0, 16'd5000);
    drain_pipeline();
    // negative depth row, zero size, oversized, extreme coefficients
    write_reg(REG_ROW2_C23, {32'h80000000, 32'h80000000});
    send_point(32'd655360, 32'd1000, 0, 16'd5000);
    drain_pipeline();
    write_reg(REG_ROW2_C01, {32'h7FFFFFFF, 32'h7FFFFFFF});
    write_reg(REG_ROW2_C23, {32'h7FFFFFFF, 32'h7FFFFFFF});
    write_reg(4'd9, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_IMG_W, 64'd0);
    write_reg(REG_IMG_H, 64'h1FFF);
    send_point(32'd655360, 32'd1000, 32'd1000, 16'd5000);
    drain_pipeline();
    write_reg(REG_ROW0_C01, 64'h0);
    write_reg(REG_ROW1_C01, 64'h0);
    write_reg(REG_ROW0_C23, {32'd10, 32'd0});
    write_reg(REG_ROW1_C23, {32'd5, 32'd0});
    write_reg(REG_ROW2_C01, 64'h0);
    write_reg(REG_ROW2_C23, {32'd1, 32'd0});
    write_reg(REG_IMG_W, 64'h1FFF);
    write_reg(REG_IMG_H, 64'd4096);
    send_point(32'd655360, 0, 0, 16'd5000);
    drain_pipeline();

    // random phases across idling patterns and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      load_camera(ph == 3 ? 1 : (ph == 5 ? 4096 : $urandom_range(4096, 64)),
                  ph == 3 ? 1 : (ph == 6 ? 8191 : $urandom_range(4096, 64)));
      phase_num = ph;
      send_random(90);
      // sender pause until all results are back
      stop_input();
      while (pending != 0) @(negedge clk);
      send_random(90);
      drain_pipeline();
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
